// File: rtl/core/prb_pkg.sv
package prb_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_RMATCH = 3'd1,
		CMD_RINDEX = 3'd2,
		CMD_BEST   = 3'd3,
		CMD_OLDEST = 3'd4,
		CMD_LOWEST = 3'd5
	} cmd_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_e;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_NONE = 2'd2;

	localparam logic [2:0]  NO_CLASS = 3'd4;
	localparam logic [30:0] TIME_TOP = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  pri;
		logic [30:0] tm;
		logic [15:0] addr;
	} rec_t;

	typedef struct packed {
		cmd_e        cmd;
		rec_t        rec;
		logic [2:0]  slot_index;
		logic [1:0]  cls;
	} req_t;

	typedef struct packed {
		logic       any;
		logic       found;
		logic [2:0] key_pri;
		rec_t       rec;
	} acc_t;

endpackage

// File: rtl/core/prb_ram.sv
module prb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/prb_eval.sv
module prb_eval import prb_pkg::*; #(
	parameter int IDX_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             proc,
	input  logic [IDX_W-1:0] idx,
	input  logic             slot_valid,
	input  req_t             req,
	input  rec_t             data,
	output acc_t             acc,
	output logic [IDX_W-1:0] pick_idx
);

	logic             any_q;
	logic             found_q;
	logic [2:0]       key_pri_q;
	logic [30:0]      key_tm_q;
	rec_t             rec_q;
	logic [IDX_W-1:0] pick_q;

	logic idx_hit;
	logic take_pick;
	logic take_rec;
	logic take_pri;
	logic take_tm;

	assign idx_hit = (32'(idx) == 32'(req.slot_index));

	always_comb begin
		take_pick = 1'b0;
		take_rec  = 1'b0;
		take_pri  = 1'b0;
		take_tm   = 1'b0;
		if (proc) begin
			case (req.cmd)
				CMD_INSERT: begin
					take_pick = !found_q && !slot_valid;
				end
				CMD_RMATCH: begin
					take_pick = slot_valid && !found_q && data.tm == req.rec.tm
						&& data.addr == req.rec.addr;
				end
				CMD_RINDEX: begin
					take_pick = slot_valid && idx_hit;
					take_rec  = take_pick;
				end
				CMD_BEST: begin
					take_pri = slot_valid && ({1'b0, data.pri} < key_pri_q);
				end
				CMD_OLDEST: begin
					take_rec = slot_valid && data.pri == req.cls && data.tm <= key_tm_q;
					take_tm  = take_rec;
				end
				CMD_LOWEST: begin
					take_rec = slot_valid && (!found_q || {1'b0, data.pri} >= key_pri_q);
					take_pri = take_rec;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (start) begin
			any_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (proc) begin
			any_q   <= any_q | slot_valid;
			found_q <= found_q | take_pick | take_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_pri_q <= NO_CLASS;
			key_tm_q  <= TIME_TOP;
		end else begin
			if (take_pri) begin
				key_pri_q <= {1'b0, data.pri};
			end
			if (take_tm) begin
				key_tm_q <= data.tm;
			end
		end
		if (take_rec) begin
			rec_q <= data;
		end
		if (take_pick) begin
			pick_q <= idx;
		end
	end

	assign acc.any     = any_q;
	assign acc.found   = found_q;
	assign acc.key_pri = key_pri_q;
	assign acc.rec     = rec_q;
	assign pick_idx    = pick_q;

endmodule

// File: rtl/core/priority_request_buffer.sv
// Each command passes through S_SCAN, S_DRAIN and S_DONE before its result is registered.
// Commands are taken only in S_IDLE and S_DONE, not during a scan; the slot RAM
// has one read port and the scan reads one slot per cycle.
// A new command is taken while an earlier result still waits at the output.
// Reset clears all slot valid bits and the control state; RAM contents are kept.
module priority_request_buffer import prb_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] req_id,
	input  logic [1:0]  req_priority,
	input  logic [30:0] req_time,
	input  logic [15:0] req_address,
	input  logic [2:0]  slot_index,
	input  logic [1:0]  package_class,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic        out_valid,
	output logic [15:0] out_id,
	output logic [2:0]  out_priority,
	output logic [30:0] out_time,
	output logic [15:0] out_address
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	state_e state_q, state_d;

	logic [IDX_W-1:0]      cnt_q;
	logic                  proc_s1;
	logic [IDX_W-1:0]      idx_s1;
	req_t                  req_q;
	logic [SLOT_COUNT-1:0] slot_valid_q;

	logic [$bits(rec_t)-1:0] ram_rdata;
	rec_t                    rd_data;
	acc_t                    acc;
	logic [IDX_W-1:0]        pick_idx;

	logic accept;
	logic load;
	logic wr_en;
	logic clr_en;

	logic [1:0] res_status;
	logic       res_hit;
	logic [2:0] res_pri;

	logic        rsp_valid_q;
	logic [1:0]  status_q;
	logic        out_valid_q;
	logic [15:0] out_id_q;
	logic [2:0]  out_pri_q;
	logic [30:0] out_time_q;
	logic [15:0] out_addr_q;

	assign accept = cmd_valid && cmd_ready;

	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		cmd_ready  = 1'b0;
		res_status = STAT_NONE;
		res_hit    = 1'b0;
		res_pri    = 3'd0;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				load      = !rsp_valid_q || rsp_ready;
				cmd_ready = load;
				if (load) begin
					state_d = cmd_valid ? S_SCAN : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		case (req_q.cmd)
			CMD_INSERT: begin
				res_status = acc.found ? STAT_OK : STAT_FULL;
			end
			CMD_RMATCH: begin
				if (!acc.any || acc.found) begin
					res_status = STAT_OK;
				end
			end
			CMD_BEST: begin
				if (acc.any) begin
					res_status = STAT_OK;
					res_pri    = acc.key_pri;
				end
			end
			CMD_RINDEX, CMD_OLDEST, CMD_LOWEST: begin
				if (acc.found) begin
					res_status = STAT_OK;
					res_hit    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_en  = load && req_q.cmd == CMD_INSERT && acc.found;
	assign clr_en = load && acc.found && (req_q.cmd == CMD_RMATCH || req_q.cmd == CMD_RINDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			proc_s1      <= 1'b0;
			slot_valid_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			proc_s1 <= (state_q == S_SCAN);
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == S_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (wr_en) begin
				slot_valid_q[pick_idx] <= 1'b1;
			end
			if (clr_en) begin
				slot_valid_q[pick_idx] <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			req_q.cmd        <= cmd_e'(cmd);
			req_q.rec.id     <= req_id;
			req_q.rec.pri    <= req_priority;
			req_q.rec.tm     <= req_time;
			req_q.rec.addr   <= req_address;
			req_q.slot_index <= slot_index;
			req_q.cls        <= package_class;
		end
		if (load) begin
			status_q    <= res_status;
			out_valid_q <= res_hit;
			out_id_q    <= res_hit ? acc.rec.id : 16'd0;
			out_pri_q   <= res_hit ? {1'b0, acc.rec.pri} : res_pri;
			out_time_q  <= res_hit ? acc.rec.tm : 31'd0;
			out_addr_q  <= res_hit ? acc.rec.addr : 16'd0;
		end
	end

	prb_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pick_idx),
		.wdata (req_q.rec),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	assign rd_data = rec_t'(ram_rdata);

	prb_eval #(
		.IDX_W(IDX_W)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.proc       (proc_s1),
		.idx        (idx_s1),
		.slot_valid (slot_valid_q[idx_s1]),
		.req        (req_q),
		.data       (rd_data),
		.acc        (acc),
		.pick_idx   (pick_idx)
	);

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign out_valid    = out_valid_q;
	assign out_id       = out_id_q;
	assign out_priority = out_pri_q;
	assign out_time     = out_time_q;
	assign out_address  = out_addr_q;

endmodule

// File: rtl/core/prb_checker.sv
module prb_port_props import prb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic        out_valid,
	input logic [15:0] out_id,
	input logic [2:0]  out_priority,
	input logic [30:0] out_time,
	input logic [15:0] out_address
);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
	else $error("command taken while a scan is running");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_id))
	else $error("pending result changed");

	a_request_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_valid |-> status == STAT_OK && out_priority != NO_CLASS)
	else $error("returned request without success status");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !out_valid |-> out_id == 16'd0 && out_time == 31'd0
			&& out_address == 16'd0)
	else $error("result fields not cleared");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STAT_OK |-> !out_valid && out_priority == 3'd0)
	else $error("failed command carries data");

endmodule

bind priority_request_buffer prb_port_props u_prb_props (.*);
